/* sv/steering_pd_gyro_feedforward_defines.svh */
// Assertion helpers shared by the checker files.
`ifndef STEERING_PD_GYRO_FEEDFORWARD_DEFINES_SVH
`define STEERING_PD_GYRO_FEEDFORWARD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPDG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering controller check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering controller check failed");

`endif

/* sv/spdg_pkg.sv */
package spdg_pkg;

  // Field widths
  localparam int ENC_W      = 12;
  localparam int Q_W        = 16;
  localparam int MAXANG_W   = 15;
  localparam int DUTY_W     = 14;
  localparam int ANGLE_W    = 24;
  localparam int ERR_W      = 25;
  localparam int DERR_W     = 26;

  // Shared multiplier and accumulator widths
  localparam int MA_W       = 27;
  localparam int MB_W       = 17;
  localparam int ACC_W      = MA_W + MB_W;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int ENCODER_COUNTS_DEF = 4096;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOME_RAW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT  = 8'd7;

  typedef struct packed {
    logic [ENC_W-1:0]        home_raw;
    logic [Q_W-1:0]          left_scale;
    logic [Q_W-1:0]          right_scale;
    logic [MAXANG_W-1:0]     max_angle;
    logic [Q_W-1:0]          prop_gain;
    logic [Q_W-1:0]          deriv_gain;
    logic signed [Q_W-1:0]   gyro_gain;
    logic [DUTY_W-1:0]       duty_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    home_raw:    12'd2139,
    left_scale:  16'd2779,
    right_scale: 16'd2333,
    max_angle:   15'd11520,
    prop_gain:   16'd0,
    deriv_gain:  16'd0,
    gyro_gain:   16'sd0,
    duty_limit:  14'd10000
  };

  // Accumulator operation of the shared MAC
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
    logic    shl8;
  } mac_ctl_t;

endpackage

/* sv/spdg_if.sv */
// Input channel: one control tick per beat
interface spdg_in_if import spdg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ENC_W-1:0]        encoder_raw;
  logic signed [Q_W-1:0]   target_angle;
  logic signed [Q_W-1:0]   gyro_rate;

  modport source (output valid, encoder_raw, target_angle, gyro_rate, input ready);
  modport sink   (input valid, encoder_raw, target_angle, gyro_rate, output ready);
endinterface

// Result channel: PWM duties and measured angle
interface spdg_out_if import spdg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DUTY_W-1:0]         duty_left_pin;
  logic [DUTY_W-1:0]         duty_right_pin;
  logic signed [ANGLE_W-1:0] measured_angle;
  logic                      saturated;

  modport source (output valid, duty_left_pin, duty_right_pin, measured_angle, saturated,
                  input ready);
  modport sink   (input valid, duty_left_pin, duty_right_pin, measured_angle, saturated,
                  output ready);
endinterface

// Register write channel
interface spdg_cfg_if import spdg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/steering_pd_gyro_feedforward.sv */
// Steering PD controller with gyro feedforward. Each input beat carries an
// absolute encoder count, a Q8.8 target angle and a gyro yaw rate; each one
// yields exactly one result beat with the left/right PWM duty, the measured
// angle (Q16.8 degrees, left negative) and a saturation flag. One signed
// 27x17 multiplier is shared for the angle scaling and the three controller
// terms, so each beat steps through S_MUL_M, S_ANGLE, S_ERR, S_MUL_P,
// S_MUL_D, S_MUL_G, S_ACC_G and S_SAT before S_OUT loads the result register,
// which waits while the previous result is still not taken; in_bus.ready is
// high only while the sequencer is idle, so the next beat is taken only after
// that load. The previous error is kept internally and cleared by reset.
// Registers may be written through cfg_bus at any time the block is idle.
module steering_pd_gyro_feedforward import spdg_pkg::*; #(
  parameter int ENCODER_COUNTS = ENCODER_COUNTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spdg_in_if.sink     in_bus,
  spdg_out_if.source  out_bus,
  spdg_cfg_if.sink    cfg_bus
);

  // Wrapped difference width: holds +-max(4096, ENCODER_COUNTS) with headroom
  localparam int SPAN = (ENCODER_COUNTS > (1 << ENC_W)) ? ENCODER_COUNTS : (1 << ENC_W);
  localparam int DW   = $clog2(SPAN) + 2;
  localparam logic signed [DW-1:0] HALF_S = DW'(ENCODER_COUNTS / 2);
  localparam logic signed [DW-1:0] EC_S   = DW'(ENCODER_COUNTS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_M,
    S_ANGLE,
    S_ERR,
    S_MUL_P,
    S_MUL_D,
    S_MUL_G,
    S_ACC_G,
    S_SAT,
    S_OUT
  } state_t;

  cfg_t                      cfg;
  mac_ctl_t                  mac_ctl;
  logic signed [MA_W-1:0]    op_a;
  logic signed [MB_W-1:0]    op_b;
  logic signed [ACC_W-1:0]   mac_prod;
  logic signed [ACC_W-1:0]   mac_acc;

  state_t                    state_r, state_nxt;
  logic signed [DW-1:0]      diff_r;
  logic signed [Q_W-1:0]     tgt_r;
  logic signed [Q_W-1:0]     gyro_r;
  logic signed [ANGLE_W-1:0] angle_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [ACC_W-1:0]   sum_r;
  logic                      sat_r;
  logic                      out_valid_r;
  logic [DUTY_W-1:0]         duty_l_r;
  logic [DUTY_W-1:0]         duty_r_r;
  logic signed [ANGLE_W-1:0] angle_out_r;
  logic                      sat_out_r;

  logic signed [DW-1:0]      diff_raw, diff_wrap;
  logic signed [MA_W-1:0]    diff_mag;
  logic signed [DERR_W-1:0]  derr;
  logic [27:0]               meas_mag;
  logic signed [ANGLE_W-1:0] angle_calc;
  logic signed [Q_W:0]       tgt_ext, lim_ext;
  logic signed [Q_W-1:0]     tgt_clamp;
  logic signed [ACC_W-1:0]   dlim;
  logic signed [ACC_W-1:0]   sum_neg;
  logic                      accept_in, out_free;

  spdg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  spdg_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (mac_prod),
    .acc  (mac_acc)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign accept_in    = in_bus.valid && (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_bus.ready;

  // Encoder difference, wrapped by half a turn
  always_comb begin
    diff_raw = DW'(signed'({1'b0, in_bus.encoder_raw})) - DW'(signed'({1'b0, cfg.home_raw}));
    if (diff_raw > HALF_S) begin
      diff_wrap = diff_raw - EC_S;
    end else if (diff_raw < -HALF_S) begin
      diff_wrap = diff_raw + EC_S;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  assign diff_mag = diff_r[DW-1] ? MA_W'(-diff_r) : MA_W'(diff_r);
  assign derr     = DERR_W'(err_r) - DERR_W'(prev_err_r);

  // Scaled count to angle: left (diff >= 0) negative, saturate to 24 bits
  assign meas_mag = mac_prod[35:8];
  always_comb begin
    if (!diff_r[DW-1]) begin
      if (meas_mag > 28'd8388608) begin
        angle_calc = ANGLE_MIN;
      end else begin
        angle_calc = ANGLE_W'(-signed'({1'b0, meas_mag}));
      end
    end else begin
      if (meas_mag > 28'd8388607) begin
        angle_calc = ANGLE_MAX;
      end else begin
        angle_calc = signed'(meas_mag[ANGLE_W-1:0]);
      end
    end
  end

  // Target clamp to +-max_angle
  always_comb begin
    tgt_ext = (Q_W + 1)'(tgt_r);
    lim_ext = signed'({2'b00, cfg.max_angle});
    if (tgt_ext > lim_ext) begin
      tgt_clamp = Q_W'(lim_ext);
    end else if (tgt_ext < -lim_ext) begin
      tgt_clamp = Q_W'(-lim_ext);
    end else begin
      tgt_clamp = tgt_r;
    end
  end

  assign dlim    = ACC_W'(signed'({1'b0, cfg.duty_limit, 16'h0000}));
  assign sum_neg = -sum_r;

  // Operand select and MAC control per step
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mac_ctl = '{mul_en: 1'b0, acc_op: ACC_HOLD, shl8: 1'b0};
    unique case (state_r)
      S_MUL_M: begin
        op_a           = diff_mag;
        op_b           = diff_r[DW-1] ? signed'({1'b0, cfg.right_scale})
                                      : signed'({1'b0, cfg.left_scale});
        mac_ctl.mul_en = 1'b1;
      end
      S_MUL_P: begin
        op_a           = MA_W'(err_r);
        op_b           = signed'({1'b0, cfg.prop_gain});
        mac_ctl.mul_en = 1'b1;
      end
      S_MUL_D: begin
        op_a           = MA_W'(derr);
        op_b           = signed'({1'b0, cfg.deriv_gain});
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_LOAD;
      end
      S_MUL_G: begin
        op_a           = MA_W'(gyro_r);
        op_b           = MB_W'(cfg.gyro_gain);
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_ADD;
      end
      S_ACC_G: begin
        mac_ctl.acc_op = ACC_ADD;
        mac_ctl.shl8   = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept_in) state_nxt = S_MUL_M;
      S_MUL_M: state_nxt = S_ANGLE;
      S_ANGLE: state_nxt = S_ERR;
      S_ERR:   state_nxt = S_MUL_P;
      S_MUL_P: state_nxt = S_MUL_D;
      S_MUL_D: state_nxt = S_MUL_G;
      S_MUL_G: state_nxt = S_ACC_G;
      S_ACC_G: state_nxt = S_SAT;
      S_SAT:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, datapath and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
    end else begin
      state_r <= state_nxt;

      // result taken; a new one loaded in S_OUT is handled below
      if (out_valid_r && out_bus.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            diff_r <= diff_wrap;
            tgt_r  <= in_bus.target_angle;
            gyro_r <= in_bus.gyro_rate;
          end
        end
        S_ANGLE: begin
          angle_r <= angle_calc;
          tgt_r   <= tgt_clamp;
        end
        S_ERR: begin
          err_r <= ERR_W'(tgt_r) - ERR_W'(angle_r);
        end
        S_SAT: begin
          if (mac_acc > dlim) begin
            sum_r <= dlim;
            sat_r <= 1'b1;
          end else if (mac_acc < -dlim) begin
            sum_r <= -dlim;
            sat_r <= 1'b1;
          end else begin
            sum_r <= mac_acc;
            sat_r <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            prev_err_r  <= err_r;
            angle_out_r <= angle_r;
            sat_out_r   <= sat_r;
            if (!sum_r[ACC_W-1]) begin
              duty_l_r <= '0;
              duty_r_r <= sum_r[29:16];
            end else begin
              duty_l_r <= sum_neg[29:16];
              duty_r_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.duty_left_pin  = duty_l_r;
  assign out_bus.duty_right_pin = duty_r_r;
  assign out_bus.measured_angle = angle_out_r;
  assign out_bus.saturated      = sat_out_r;

endmodule

/* sv/spdg_cfg.sv */
// Configuration register file, always ready for a write beat
module spdg_cfg import spdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  spdg_cfg_if.sink    cfg_bus,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  assign cfg_bus.ready = 1'b1;
  assign cfg          = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_HOME_RAW:    cfg_r.home_raw    <= cfg_bus.data[ENC_W-1:0];
        REG_LEFT_SCALE:  cfg_r.left_scale  <= cfg_bus.data[Q_W-1:0];
        REG_RIGHT_SCALE: cfg_r.right_scale <= cfg_bus.data[Q_W-1:0];
        REG_MAX_ANGLE:   cfg_r.max_angle   <= cfg_bus.data[MAXANG_W-1:0];
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_bus.data[Q_W-1:0];
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_bus.data[Q_W-1:0];
        REG_GYRO_GAIN:   cfg_r.gyro_gain   <= signed'(cfg_bus.data[Q_W-1:0]);
        REG_DUTY_LIMIT:  cfg_r.duty_limit  <= cfg_bus.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/spdg_mac.sv */
// Shared signed multiplier with registered product and an accumulator behind it
module spdg_mac import spdg_pkg::*; (
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [MA_W-1:0]   op_a,
  input  logic signed [MB_W-1:0]   op_b,
  output logic signed [ACC_W-1:0]  prod,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] addend;

  // Gyro term carries an extra x256
  assign addend = ctl.shl8 ? (prod_r <<< 8) : prod_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= addend;
      ACC_ADD:  acc_r <= acc_r + addend;
      default:  ;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

/* sv/spdg_chk.sv */
`include "steering_pd_gyro_feedforward_defines.svh"

// Port-level checks for the steering controller
module spdg_chk import spdg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] duty_left_pin,
  input logic [DUTY_W-1:0] duty_right_pin
);

  // Only one PWM channel drives at a time
  `SPDG_ASSERT_NOW(a_one_channel, clk, rst_n, out_valid, (duty_left_pin == '0) || (duty_right_pin == '0))

  // An accepted beat keeps the block busy in the next cycle
  `SPDG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A new result only appears at the end of a busy period
  `SPDG_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // A pending result stays until taken
  `SPDG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind steering_pd_gyro_feedforward spdg_chk u_spdg_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .duty_left_pin  (out_bus.duty_left_pin),
  .duty_right_pin (out_bus.duty_right_pin)
);
